// ===== rtl/core/rtms_pkg.sv =====
package rtms_pkg;

    localparam int COUNT_BITS = 16;
    localparam int OUT_CNT    = 16;
    localparam int QDEPTH     = 2;

    // Command codes
    localparam logic CMD_HIT = 1'b0;
    localparam logic CMD_END = 1'b1;

    // Classified item passed from front to back
    typedef struct packed {
        logic                  is_end;
        logic signed [31:0]    hit_time;
    } t_op;

endpackage

// ===== rtl/core/rtms_front.sv =====
module rtms_front (
    input  logic              i_cfg_first,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_tuser,   // cmd
    input  logic [33:0]       i_data,    // hit_time[31:0], time_invalid, first_in_module
    output logic              o_push,
    output rtms_pkg::t_op     o_op,
    input  logic              i_full
);
    import rtms_pkg::*;

    logic w_cmd, w_inv, w_first, w_keep;

    // Unpack and filter: dropped hits are consumed without a queue entry
    assign w_cmd   = i_tuser;
    assign w_inv   = i_data[32];
    assign w_first = i_data[33];
    assign w_keep  = (w_cmd == CMD_END) || (!w_inv && (!i_cfg_first || w_first));
    assign o_ready = !i_full;
    assign o_push  = i_valid && o_ready && w_keep;
    assign o_op.is_end   = (w_cmd == CMD_END);
    assign o_op.hit_time = i_data[31:0];
endmodule

// ===== rtl/core/rtms_queue.sv =====
module rtms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtms_pkg::t_op     i_op,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output rtms_pkg::t_op     o_op
);
    import rtms_pkg::*;

    t_op  r_mem [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];

    // Two-entry FIFO
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_op;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("push to full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && !o_valid))
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDEPTH))
        else $error("queue count out of range");
endmodule

// ===== rtl/core/rtms_back.sv =====
module rtms_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rtms_pkg::t_op     i_op,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [87:0]       o_tdata
);
    import rtms_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_ABS  = 8'b00000010, S_SQR  = 8'b00000100,
        S_DIV  = 8'b00001000, S_UPD  = 8'b00010000, S_ACC  = 8'b00100000,
        S_VDIV = 8'b01000000, S_SQRT = 8'b10000000
    } t_state;

    t_state r_st;
    logic signed [31:0] r_mean;
    logic [63:0]  r_sum;
    logic [COUNT_BITS-1:0] r_cnt;
    logic r_ovf;
    logic signed [32:0] r_delta;
    logic r_neg;
    logic [31:0] r_mag;
    logic [63:0] r_d2;                 // delta squared, then the sum increment
    logic [63:0] r_qa;                 // wide dividend/quotient, then radicand
    logic [COUNT_BITS-1:0] r_ra;
    logic [31:0] r_qb;                 // |delta| dividend/quotient
    logic [COUNT_BITS-1:0] r_rb;
    logic [COUNT_BITS-1:0] r_div;
    logic [5:0]  r_it;
    logic [63:0] r_root, r_bit;
    logic r_o_valid;
    logic [31:0] r_o_mean, r_o_sd;
    logic [OUT_CNT-1:0] r_o_cnt;
    logic r_o_few, r_o_ovf;

    // One restoring divide step: {quotient bit, new remainder}
    function automatic logic [COUNT_BITS:0] div_step(input logic [COUNT_BITS-1:0] rem,
                                                     input logic din,
                                                     input logic [COUNT_BITS-1:0] dvs);
        logic [COUNT_BITS:0] cat;
        cat = {rem, din};
        if (cat >= {1'b0, dvs}) return {1'b1, COUNT_BITS'(cat - {1'b0, dvs})};
        return {1'b0, cat[COUNT_BITS-1:0]};
    endfunction

    logic [COUNT_BITS:0] w_step_a, w_step_b;
    assign w_step_a = div_step(r_ra, r_qa[63], r_div);
    assign w_step_b = div_step(r_rb, r_qb[31], r_div);

    logic [63:0] w_sq;
    assign w_sq = {32'd0, r_mag} * {32'd0, r_mag};

    logic [64:0] w_sumadd;
    assign w_sumadd = {1'b0, r_sum} + {1'b0, r_d2};

    logic [64:0] w_sq_t;
    assign w_sq_t = {1'b0, r_qa} - ({1'b0, r_root} + {1'b0, r_bit});

    logic w_res_done;
    assign w_res_done = ((r_st == S_SQRT) && (r_bit == '0)) ||
                        (o_pop && i_op.is_end && (r_cnt < COUNT_BITS'(2)));

    // Hits go on while a result waits; an end item waits for the result register
    assign o_pop    = (r_st == S_IDLE) && i_valid && (!i_op.is_end || !r_o_valid);
    assign o_tvalid = r_o_valid;
    assign o_tdata  = {6'd0, r_o_ovf, r_o_few, r_o_cnt, r_o_sd, r_o_mean};

    // Statistics and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mean <= '0; r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (o_pop && i_op.is_end) begin
                        r_o_mean <= r_mean;
                        r_o_cnt  <= OUT_CNT'(r_cnt);
                        r_o_ovf  <= r_ovf;
                        r_o_few  <= (r_cnt < COUNT_BITS'(2));
                        r_o_sd   <= '0;
                        r_qa     <= r_sum;
                        r_ra     <= '0;
                        r_div    <= r_cnt - COUNT_BITS'(1);
                        r_it     <= '0;
                        // statistics restart for the next event
                        r_mean <= '0; r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
                        if (r_cnt >= COUNT_BITS'(2)) r_st <= S_VDIV;
                    end else if (o_pop && r_cnt == '1) begin
                        r_ovf <= 1'b1;
                    end else if (o_pop) begin
                        r_cnt   <= r_cnt + COUNT_BITS'(1);
                        r_delta <= {i_op.hit_time[31], i_op.hit_time} - {r_mean[31], r_mean};
                        r_st    <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg <= r_delta[32];
                    r_mag <= r_delta[32] ? 32'(-r_delta) : r_delta[31:0];
                    r_st  <= S_SQR;
                end
                S_SQR: begin
                    r_d2 <= w_sq; r_qa <= w_sq; r_ra <= '0;
                    r_qb <= r_mag; r_rb <= '0;
                    r_div <= r_cnt; r_it <= '0;
                    r_st <= S_DIV;
                end
                // d2/n over 64 steps, |delta|/n over the last 32
                S_DIV: begin
                    r_qa <= {r_qa[62:0], w_step_a[COUNT_BITS]};
                    r_ra <= w_step_a[COUNT_BITS-1:0];
                    if (r_it[5]) begin
                        r_qb <= {r_qb[30:0], w_step_b[COUNT_BITS]};
                        r_rb <= w_step_b[COUNT_BITS-1:0];
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd63) r_st <= S_UPD;
                end
                // mean moves by |delta|/n; (n-1)*d2/n = d2 - ceil(d2/n)
                S_UPD: begin
                    r_mean <= r_neg ? r_mean - r_qb : r_mean + r_qb;
                    r_d2   <= r_d2 - r_qa - 64'(r_ra != '0);
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= w_sumadd[64] ? '1 : w_sumadd[63:0];
                    r_st  <= S_IDLE;
                end
                S_VDIV: begin
                    r_qa <= {r_qa[62:0], w_step_a[COUNT_BITS]};
                    r_ra <= w_step_a[COUNT_BITS-1:0];
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd63) begin
                        r_root <= '0; r_bit <= 64'h4000_0000_0000_0000;
                        r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_o_sd <= r_root[31:0];
                        r_st <= S_IDLE;
                    end else begin
                        if (!w_sq_t[64]) begin
                            r_qa <= w_sq_t[63:0];
                            r_root <= (r_root >> 1) + r_bit;
                        end else r_root <= r_root >> 1;
                        r_bit <= r_bit >> 2;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (w_res_done) r_o_valid <= 1'b1;
        else if (i_tready) r_o_valid <= 1'b0;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_tvalid && !i_tready |=> o_tvalid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_tvalid && !i_tready |=> $stable(o_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     o_tvalid |-> r_o_few || r_o_cnt >= OUT_CNT'(2))
        else $error("few flag mismatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_res_done |-> !r_o_valid)
        else $error("result overwritten");
endmodule

// ===== rtl/core/running_time_mean_stddev_core.sv =====
// An end item taken by an idle back end gets its result after a 64-step variance divide and a
// 32-step square root, or without either with fewer than two hits. A kept hit holds the back end
// through a 64-step divide of its squared delta by the count, with a 32-step divide of |delta|
// side by side over its last 32 steps; no new item is taken until the back end is idle again, and
// skipped hits never reach the back end. A two-entry queue decouples front and back. Reset is
// synchronous, active low, and clears statistics, the queue, the result valid flag and first_hit_only.
module running_time_mean_stddev_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,  // cmd
    input  logic [39:0] s_axis_tdata,  // hit_time[31:0], time_invalid, first_in_module
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // mean_time, std_dev, hits_used, too_few_hits, count_overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data     // first_hit_only
);
    import rtms_pkg::*;

    logic r_first;
    logic w_push, w_full, w_qv, w_pop;
    t_op  w_op_in, w_op_out;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= 1'b0;
        else if (i_cfg_valid) r_first <= i_cfg_data;
    end

    rtms_front u_front (.i_cfg_first(r_first), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_tuser(s_axis_tuser), .i_data(s_axis_tdata[33:0]),
        .o_push(w_push), .o_op(w_op_in), .i_full(w_full));
    rtms_queue u_queue (.i_clk, .i_rst_n, .i_push(w_push), .i_op(w_op_in), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qv), .o_op(w_op_out));
    rtms_back u_back (.i_clk, .i_rst_n, .i_valid(w_qv), .i_op(w_op_out), .o_pop(w_pop),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready), .o_tdata(m_axis_tdata));
endmodule
